/* rtl/cea_pkg.sv */
// ----------------------------------------------------------------------------
// cea_pkg
// Shared codes, constants and transaction types of the effective-address unit.
// ----------------------------------------------------------------------------
package cea_pkg;

  // Register file: data registers at 0..7, address registers at 8..15.
  localparam int RF_DEPTH = 16;
  localparam int RF_AW    = 4;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // Commands
  localparam logic [1:0] CMD_ADDR  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_BAD   = 2'd3;

  // Addressing modes
  localparam logic [2:0] MD_DREG  = 3'd0;
  localparam logic [2:0] MD_AREG  = 3'd1;
  localparam logic [2:0] MD_IND   = 3'd2;
  localparam logic [2:0] MD_POST  = 3'd3;
  localparam logic [2:0] MD_PRE   = 3'd4;
  localparam logic [2:0] MD_D16   = 3'd5;
  localparam logic [2:0] MD_IDX   = 3'd6;
  localparam logic [2:0] MD_OTHER = 3'd7;

  // Submodes of the "other" mode
  localparam logic [2:0] SUB_ABSW  = 3'd0;
  localparam logic [2:0] SUB_ABSL  = 3'd1;
  localparam logic [2:0] SUB_PCD16 = 3'd2;
  localparam logic [2:0] SUB_PCIDX = 3'd3;
  localparam logic [2:0] SUB_IMM   = 3'd4;

  // Operand sizes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;
  localparam logic [1:0] SZ_LONG = 2'd2;
  localparam logic [1:0] SZ_BAD  = 2'd3;

  // Outcomes
  localparam logic [1:0] OC_REG     = 2'd0;
  localparam logic [1:0] OC_MEM     = 2'd1;
  localparam logic [1:0] OC_NONE    = 2'd2;
  localparam logic [1:0] OC_INVALID = 2'd3;

  // The stack pointer keeps word alignment on byte steps.
  localparam logic [2:0] REG_SP = 3'd7;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  mode;
    logic [2:0]  reg_req;
    logic [1:0]  size;
    logic [15:0] ext_first;
    logic [15:0] ext_second;
    logic [31:0] pc_now;
    logic [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [31:0] address;
    logic [31:0] operand_value;
    logic [1:0]  ext_words_used;
    logic [1:0]  access_size;
    logic        mem_write;
  } res_t;

  typedef struct packed {
    logic             en;
    logic [RF_AW-1:0] idx;
    logic [31:0]      data;
  } wb_t;

endpackage

/* rtl/cea_ram.sv */
// ----------------------------------------------------------------------------
// cea_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module cea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/cea_exec.sv */
// ----------------------------------------------------------------------------
// cea_exec
// Operand resolution: address arithmetic, operand masking and the register
// write-back that a transaction implies.
// ----------------------------------------------------------------------------
module cea_exec import cea_pkg::*; (
  input  req_t        req,
  input  logic [31:0] base_val,
  input  logic [31:0] index_val,
  output res_t        res,
  output wb_t         wb
);

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sext8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  logic        invalid;
  logic [31:0] mask;
  logic [31:0] step;
  logic [31:0] idx_off;

  always_comb begin
    invalid = (req.command == CMD_BAD) || (req.size == SZ_BAD) ||
              (req.mode == MD_AREG && req.size == SZ_BYTE) ||
              (req.mode == MD_OTHER && req.reg_req > SUB_IMM) ||
              (req.mode == MD_OTHER && req.reg_req == SUB_IMM &&
               req.command == CMD_WRITE);

    case (req.size)
      SZ_BYTE: mask = 32'h0000_00FF;
      SZ_WORD: mask = 32'h0000_FFFF;
      default: mask = ALL_ONES;
    endcase

    case (req.size)
      SZ_BYTE: step = (req.reg_req == REG_SP) ? 32'd2 : 32'd1;
      SZ_WORD: step = 32'd2;
      default: step = 32'd4;
    endcase

    // Index word: bit 11 picks the whole register or its sign-extended low word.
    idx_off = sext8(req.ext_first[7:0]) +
              (req.ext_first[11] ? index_val : sext16(index_val[15:0]));

    res = '{outcome: OC_INVALID, address: ALL_ONES, operand_value: '0,
            ext_words_used: '0, access_size: '0, mem_write: 1'b0};
    wb  = '{en: 1'b0, idx: {(req.mode != MD_DREG), req.reg_req}, data: '0};

    if (!invalid) begin
      if (req.mode == MD_DREG || req.mode == MD_AREG) begin
        if (req.command == CMD_ADDR) begin
          res.outcome = OC_NONE;
        end else if (req.command == CMD_READ) begin
          res.outcome       = OC_REG;
          res.operand_value = base_val & mask;
        end else begin
          res.outcome = OC_REG;
          wb.en       = 1'b1;
          if (req.mode == MD_DREG) begin
            wb.data = (base_val & ~mask) | (req.write_value & mask);
          end else begin
            wb.data = (req.size == SZ_WORD) ? sext16(req.write_value[15:0])
                                            : req.write_value;
          end
        end
      end else if (req.mode == MD_OTHER && req.reg_req == SUB_IMM) begin
        res.address        = req.pc_now;
        res.ext_words_used = (req.size == SZ_LONG) ? 2'd2 : 2'd1;
        if (req.command == CMD_READ) begin
          res.outcome       = OC_REG;
          res.operand_value = (req.size == SZ_LONG) ?
                              {req.ext_first, req.ext_second} :
                              ({16'h0000, req.ext_first} & mask);
        end else begin
          res.outcome = OC_MEM;
        end
      end else begin
        res.outcome = OC_MEM;
        unique case (req.mode)
          MD_IND: res.address = base_val;
          MD_POST: begin
            res.address = base_val;
            wb.en       = (req.command != CMD_ADDR);
            wb.data     = base_val + step;
          end
          MD_PRE: begin
            res.address = base_val - step;
            wb.en       = (req.command != CMD_ADDR);
            wb.data     = base_val - step;
          end
          MD_D16: begin
            res.address        = base_val + sext16(req.ext_first);
            res.ext_words_used = 2'd1;
          end
          MD_IDX: begin
            res.address        = base_val + idx_off;
            res.ext_words_used = 2'd1;
          end
          default: begin
            unique case (req.reg_req)
              SUB_ABSW: begin
                res.address        = sext16(req.ext_first);
                res.ext_words_used = 2'd1;
              end
              SUB_ABSL: begin
                res.address        = {req.ext_first, req.ext_second};
                res.ext_words_used = 2'd2;
              end
              SUB_PCD16: begin
                res.address        = req.pc_now + sext16(req.ext_first);
                res.ext_words_used = 2'd1;
              end
              default: begin
                res.address        = req.pc_now + idx_off;
                res.ext_words_used = 2'd1;
              end
            endcase
          end
        endcase
      end
    end

    res.access_size = (res.outcome == OC_MEM) ? req.size : 2'd0;
    res.mem_write   = (res.outcome == OC_MEM) && (req.command == CMD_WRITE);
  end

endmodule

/* rtl/cpu_effective_address_unit.sv */
// ----------------------------------------------------------------------------
// cpu_effective_address_unit
// Effective-address unit with eight data and eight address registers.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one operand request per
//   transaction; the output channel (out_valid/out_ready) returns exactly one
//   result transaction for each request, in order.
//   The registers live in two copies of a 16-entry synchronous RAM: one port
//   reads the base register, the other the index register of d8 modes. Both
//   are read at acceptance, the result is computed in the following cycle,
//   and the register write-back and the result register load happen together
//   once the output register is free. A new request is taken only in the idle
//   state, once the last has left execute, for the register RAM read-modify-write.
//   A new request may be accepted while a result still waits in the output
//   register. If the receiver stalls, the unit holds the next request in its
//   execute cycle, with no register write, until the output register frees.
//   Synchronous reset empties the output register and marks all sixteen
//   registers as cleared through valid bits, so no clearing pass is needed;
//   a request may be accepted in the first cycle after reset.
// ----------------------------------------------------------------------------
module cpu_effective_address_unit import cea_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [2:0]  mode,
  input  logic [2:0]  reg_req,
  input  logic [1:0]  size,
  input  logic [15:0] ext_first,
  input  logic [15:0] ext_second,
  input  logic [31:0] pc_now,
  input  logic [31:0] write_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  outcome,
  output logic [31:0] address,
  output logic [31:0] operand_value,
  output logic [1:0]  ext_words_used,
  output logic [1:0]  access_size,
  output logic        mem_write
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  req_t              req;
  logic [RF_DEPTH-1:0] reg_valid;
  logic              base_vld, index_vld;
  logic [RF_AW-1:0]  base_addr, index_addr;
  logic [31:0]       base_raw, index_raw;
  logic [31:0]       base_val, index_val;
  res_t              res;
  wb_t               wb;
  logic              accept;
  logic              out_load;
  logic              wr_en;

  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_load   = (state == ST_EXEC) && (!out_valid || out_ready);
  assign wr_en      = out_load && wb.en;

  assign base_addr  = {(mode != MD_DREG), reg_req};
  assign index_addr = ext_first[15:12];

  // Entries never written since reset read as zero.
  assign base_val   = base_vld  ? base_raw  : 32'h0;
  assign index_val  = index_vld ? index_raw : 32'h0;

  cea_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_base_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wb.idx),
    .wr_data (wb.data),
    .rd_en   (accept),
    .rd_addr (base_addr),
    .rd_data (base_raw)
  );

  cea_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_index_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wb.idx),
    .wr_data (wb.data),
    .rd_en   (accept),
    .rd_addr (index_addr),
    .rd_data (index_raw)
  );

  cea_exec u_exec (
    .req       (req),
    .base_val  (base_val),
    .index_val (index_val),
    .res       (res),
    .wb        (wb)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept)   state_next = ST_EXEC;
      ST_EXEC: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      reg_valid <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        reg_valid[wb.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req       <= '{command: command, mode: mode, reg_req: reg_req, size: size,
                     ext_first: ext_first, ext_second: ext_second,
                     pc_now: pc_now, write_value: write_value};
      base_vld  <= reg_valid[base_addr];
      index_vld <= reg_valid[index_addr];
    end
    if (out_load) begin
      outcome        <= res.outcome;
      address        <= res.address;
      operand_value  <= res.operand_value;
      ext_words_used <= res.ext_words_used;
      access_size    <= res.access_size;
      mem_write      <= res.mem_write;
    end
  end

  // An accepted request always spends the next cycle in execute.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC))
    else $error("accepted request did not enter execute");

  // A result appears only after an execute cycle.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EXEC))
    else $error("result without execute cycle");

  // An invalid request leaves the register file untouched.
  assert property (@(posedge clk) disable iff (rst)
    (out_load && res.outcome == OC_INVALID) |-> !wr_en)
    else $error("register write on invalid request");

  // A write-back that is stalled by the receiver is held, not lost.
  assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EXEC) && !out_load) |=> ((state == ST_EXEC) && $stable(req)))
    else $error("stalled request lost");

endmodule
